[src/assert_macros.svh]
// Assertion macros used by the checker file of the slot table.
// Depends on nothing; take it in by a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/kvst_pkg.sv]
// Shared types and codes of the key/value slot table.
// Used by the controller, the datapath, the top level and the checker.
package kvst_pkg;

    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int KEY_FIELD_W   = 64;
    localparam int VALUE_FIELD_W = 64;
    localparam int S_TDATA_W     = 136;
    localparam int M_TDATA_W     = 72;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 3'd2;
    localparam logic [OP_W-1:0] OP_MOD   = 3'd3;
    localparam logic [OP_W-1:0] OP_EXIST = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_DONE
    } kvst_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic start;
        logic scan;
        logic act;
        logic trim_rd;
        logic trim_chk;
        logic load_out;
    } kvst_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_end;
        logic trim_req;
        logic hw_zero;
        logic slot_used;
        logic out_free;
    } kvst_sts_t;

endpackage

[src/kvst_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kvst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/kvst_ctrl.sv]
// Sequencer of the slot table: scan, act, trim and hand-off of one request.
// Depends on kvst_pkg; drives the datapath through kvst_cmd_t.
module kvst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  kvst_pkg::kvst_sts_t sts,
    output kvst_pkg::kvst_cmd_t cmd
);
    import kvst_pkg::*;

    kvst_state_t state_reg;
    kvst_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_end) begin
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                state_next = sts.trim_req ? S_TRIM_RD : S_DONE;
            end
            S_TRIM_RD: begin
                state_next = sts.hw_zero ? S_DONE : S_TRIM_CHK;
            end
            S_TRIM_CHK: begin
                // stop at the first used slot from the top
                state_next = sts.slot_used ? S_DONE : S_TRIM_RD;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_SCAN:     cmd.scan     = 1'b1;
            S_ACT:      cmd.act      = 1'b1;
            S_TRIM_RD:  cmd.trim_rd  = !sts.hw_zero;
            S_TRIM_CHK: cmd.trim_chk = 1'b1;
            S_DONE:     cmd.load_out = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/kvst_dp.sv]
// Datapath of the slot table: key and value memories, scan pipeline,
// high-water count, result and output registers. Depends on kvst_pkg, kvst_ram.
module kvst_dp #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kvst_pkg::kvst_cmd_t                cmd,
    input  logic [kvst_pkg::OP_W-1:0]          in_operation,
    input  logic [kvst_pkg::KEY_FIELD_W-1:0]   in_key,
    input  logic [kvst_pkg::VALUE_FIELD_W-1:0] in_value,
    output kvst_pkg::kvst_sts_t                sts,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [kvst_pkg::STATUS_W-1:0]      out_status,
    output logic                               out_found,
    output logic [kvst_pkg::VALUE_FIELD_W-1:0] out_value
);
    import kvst_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // request payload
    logic [OP_W-1:0]       op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // scan state
    logic [CNT_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic                  hole_found_reg, hole_found_next;
    logic [IDX_W-1:0]      hole_idx_reg;
    logic [VALUE_BITS-1:0] hit_value_reg;
    logic [CNT_W-1:0]      hw_reg, hw_next;

    // result and output
    logic [STATUS_W-1:0]      res_status_reg;
    logic                     res_found_reg;
    logic [VALUE_FIELD_W-1:0] res_value_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      out_status_reg;
    logic                     out_found_reg;
    logic [VALUE_FIELD_W-1:0] out_value_reg;

    // memory ports
    logic                  key_we, val_we;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [KEY_BITS:0]     key_wdata, key_rdata;
    logic [VALUE_BITS-1:0] val_wdata, val_rdata;

    logic                  rd_used;
    logic                  issue, hit_now, hole_now;
    logic [CNT_W-1:0]      hw_dec;
    logic                  top_hit;

    // act decode
    logic                     a_key_we, a_val_we, a_append, a_drop_top, a_found;
    logic [STATUS_W-1:0]      a_status;
    logic [VALUE_FIELD_W-1:0] a_value;

    kvst_ram #(.WIDTH(KEY_BITS + 1), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (aclk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    kvst_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
        .clk   (aclk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    assign rd_used  = key_rdata[KEY_BITS];
    assign hw_dec   = hw_reg - CNT_W'(1);
    assign top_hit  = (CNT_W'(hit_idx_reg) + CNT_W'(1)) == hw_reg;

    // compare the slot read last cycle; drop anything after the first hit
    assign hit_now  = cmd.scan && pend_valid_reg && !hit_reg && rd_used
                      && (key_rdata[KEY_BITS-1:0] == key_reg);
    assign hole_now = cmd.scan && pend_valid_reg && !hit_reg && !rd_used && !hole_found_reg;
    assign issue    = cmd.scan && !hit_reg && !hit_now && (issue_idx_reg < hw_reg);

    assign rd_addr  = cmd.trim_rd ? hw_dec[IDX_W-1:0] : issue_idx_reg[IDX_W-1:0];

    always_comb begin
        a_key_we   = 1'b0;
        a_val_we   = 1'b0;
        a_append   = 1'b0;
        a_drop_top = 1'b0;
        a_found    = hit_reg;
        a_status   = ST_OK;
        a_value    = '0;
        wr_addr    = hit_idx_reg;
        key_wdata  = {1'b1, key_reg};
        val_wdata  = val_reg;
        unique case (op_reg)
            OP_SET: begin
                if (hw_reg == CNT_W'(ENTRIES)) begin
                    a_status = ST_FULL;
                end else if (hit_reg) begin
                    a_status = ST_DUP;
                end else begin
                    a_key_we = 1'b1;
                    a_val_we = 1'b1;
                    a_append = !hole_found_reg;
                    wr_addr  = hole_found_reg ? hole_idx_reg : hw_reg[IDX_W-1:0];
                end
            end
            OP_GET: begin
                if (hit_reg) begin
                    a_value = VALUE_FIELD_W'(hit_value_reg);
                end else begin
                    a_status = ST_MISSING;
                end
            end
            OP_DEL: begin
                if (hit_reg) begin
                    a_key_we   = 1'b1;
                    key_wdata  = {1'b0, key_reg};
                    a_drop_top = top_hit;
                end else begin
                    a_status = ST_MISSING;
                end
            end
            OP_MOD: begin
                if (hit_reg) begin
                    a_val_we = 1'b1;
                end else begin
                    a_status = ST_MISSING;
                end
            end
            OP_EXIST: begin
                if (!hit_reg) begin
                    a_status = ST_MISSING;
                end
            end
            default: begin
                // undefined code: no change, all-zero result
                a_found = 1'b0;
            end
        endcase
    end

    assign key_we = cmd.act && a_key_we;
    assign val_we = cmd.act && a_val_we;

    always_comb begin
        issue_idx_next  = issue_idx_reg;
        pend_valid_next = pend_valid_reg;
        hit_next        = hit_reg;
        hole_found_next = hole_found_reg;
        if (cmd.start) begin
            issue_idx_next  = '0;
            pend_valid_next = 1'b0;
            hit_next        = 1'b0;
            hole_found_next = 1'b0;
        end else if (cmd.scan) begin
            pend_valid_next = issue;
            if (issue) begin
                issue_idx_next = issue_idx_reg + CNT_W'(1);
            end
            if (hit_now) begin
                hit_next = 1'b1;
            end
            if (hole_now) begin
                hole_found_next = 1'b1;
            end
        end
    end

    always_comb begin
        hw_next = hw_reg;
        priority if (cmd.act && a_append) begin
            hw_next = hw_reg + CNT_W'(1);
        end else if (cmd.act && a_drop_top) begin
            hw_next = CNT_W'(hit_idx_reg);
        end else if (cmd.trim_chk && !rd_used) begin
            hw_next = hw_dec;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_idx_reg  <= '0;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            hole_found_reg <= 1'b0;
            hw_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            issue_idx_reg  <= issue_idx_next;
            pend_valid_reg <= pend_valid_next;
            hit_reg        <= hit_next;
            hole_found_reg <= hole_found_next;
            hw_reg         <= hw_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg         <= in_operation;
            key_reg        <= in_key[KEY_BITS-1:0];
            val_reg        <= in_value[VALUE_BITS-1:0];
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
            res_value_reg  <= '0;
        end
        if (issue) begin
            pend_idx_reg <= issue_idx_reg[IDX_W-1:0];
        end
        if (hit_now) begin
            hit_idx_reg   <= pend_idx_reg;
            hit_value_reg <= val_rdata;
        end
        if (hole_now) begin
            hole_idx_reg <= pend_idx_reg;
        end
        if (cmd.act) begin
            res_status_reg <= a_status;
            res_found_reg  <= a_found;
            res_value_reg  <= a_value;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign sts.scan_end  = hit_reg || (!pend_valid_reg && (issue_idx_reg == hw_reg));
    assign sts.trim_req  = hit_reg && (op_reg == OP_DEL) && top_hit;
    assign sts.hw_zero   = (hw_reg == '0);
    assign sts.slot_used = rd_used;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_value  = out_value_reg;

endmodule

[src/key_value_slot_table.sv]
// The time from accepted request to m_tvalid grows with HW, the high-water count
// before it; a delete of the top slot adds a trim step over the trailing holes.
// One request at a time; the linear scan reads one slot per cycle up to HW, and a
// full trim walks down over every trailing hole to the last used slot.
// Reset (aresetn low, synchronous) zeroes the high-water count and drops any
// pending result; memories keep their contents and need no clearing pass.
module key_value_slot_table #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation [2:0], lookup_key [66:3], new_value [130:67], zero pad above
    input  logic [kvst_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status [1:0], found [2], read_value [66:3], zero pad above
    output logic [kvst_pkg::M_TDATA_W-1:0]   m_tdata
);
    import kvst_pkg::*;

    kvst_cmd_t cmd;
    kvst_sts_t sts;

    logic [STATUS_W-1:0]      out_status;
    logic                     out_found;
    logic [VALUE_FIELD_W-1:0] out_value;

    kvst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kvst_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_operation (s_tdata[2:0]),
        .in_key       (s_tdata[66:3]),
        .in_value     (s_tdata[130:67]),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_found    (out_found),
        .out_value    (out_value)
    );

    assign m_tdata = {5'b0, out_value, out_found, out_status};

endmodule

[src/kvst_checker.sv]
// Port-level checks of the slot table, bound to the top level.
// Depends on kvst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvst_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [kvst_pkg::M_TDATA_W-1:0] m_tdata
);
    import kvst_pkg::*;

    logic [STATUS_W-1:0]      m_status;
    logic                     m_found;
    logic [VALUE_FIELD_W-1:0] m_value;
    logic                     m_dup_or_miss;

    assign m_status      = m_tdata[1:0];
    assign m_found       = m_tdata[2];
    assign m_value       = m_tdata[66:3];
    assign m_dup_or_miss = (m_status == ST_DUP) || (m_status == ST_MISSING);

    // hold a stalled response
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one request in flight: busy right after accepting
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a nonzero value only comes back from a successful lookup
    `ASSERT_IMPLY(a_value_on_hit, aclk, aresetn, m_tvalid && |m_value, m_status == ST_OK && m_found)
    // duplicate means present, missing means absent
    `ASSERT_IMPLY(a_found_status, aclk, aresetn, m_tvalid && m_dup_or_miss, m_found == (m_status == ST_DUP))

endmodule

bind key_value_slot_table kvst_checker u_checker (.*);
